[rtl/brl_pkg.sv]
package brl_pkg;

   localparam int unsigned ColorBits = 4;
   localparam logic [ColorBits-1:0] ColorReset = 4'hF;

   localparam logic ModeStart   = 1'b0;
   localparam logic ModeAdvance = 1'b1;

   typedef struct packed {
      logic x_neg;
      logic y_neg;
   } brl_dir_type;

   typedef struct packed {
      logic emit;
      logic last;
      logic busy;
   } brl_status_type;

endpackage

[rtl/brl_req_if.sv]
interface brl_req_if #(
   parameter int unsigned COORD_BITS = 12
);
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic signed [COORD_BITS-1:0] x_start;
   logic signed [COORD_BITS-1:0] y_start;
   logic signed [COORD_BITS-1:0] x_end;
   logic signed [COORD_BITS-1:0] y_end;

   modport source (output valid, mode, x_start, y_start, x_end, y_end, input ready);
   modport sink   (input valid, mode, x_start, y_start, x_end, y_end, output ready);
endinterface

[rtl/brl_rsp_if.sv]
interface brl_rsp_if
   import brl_pkg::*;
#(
   parameter int unsigned COORD_BITS = 12
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic [ColorBits-1:0]         pixel_color;
   logic                         last;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

[rtl/brl_csr_if.sv]
interface brl_csr_if
   import brl_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [ColorBits-1:0] draw_color;

   modport source (output valid, draw_color, input ready);
   modport sink   (input valid, draw_color, output ready);
endinterface

[rtl/brl_step.sv]
module brl_step
   import brl_pkg::*;
#(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                                 mode,
   input  logic signed [COORD_BITS-1:0]         x_start,
   input  logic signed [COORD_BITS-1:0]         y_start,
   input  logic signed [COORD_BITS-1:0]         x_end,
   input  logic signed [COORD_BITS-1:0]         y_end,
   input  logic                                 busy,
   input  logic signed [COORD_BITS-1:0]         cur_x,
   input  logic signed [COORD_BITS-1:0]         cur_y,
   input  logic signed [COORD_BITS-1:0]         tgt_x,
   input  logic signed [COORD_BITS-1:0]         tgt_y,
   input  logic        [COORD_BITS-1:0]         delta_x,
   input  logic        [COORD_BITS-1:0]         delta_y,
   input  brl_dir_type                          dir,
   input  logic signed [COORD_BITS+1:0]         error_term,
   output logic signed [COORD_BITS-1:0]         cur_x_in,
   output logic signed [COORD_BITS-1:0]         cur_y_in,
   output logic signed [COORD_BITS-1:0]         tgt_x_in,
   output logic signed [COORD_BITS-1:0]         tgt_y_in,
   output logic        [COORD_BITS-1:0]         delta_x_in,
   output logic        [COORD_BITS-1:0]         delta_y_in,
   output brl_dir_type                          dir_in,
   output logic signed [COORD_BITS+1:0]         error_in,
   output brl_status_type                       status
);

   localparam int unsigned ErrBits  = COORD_BITS + 2;
   localparam int unsigned WideBits = ErrBits + 2;

   logic                         start;
   logic signed [COORD_BITS:0]   dx_full;
   logic signed [COORD_BITS:0]   dy_full;
   logic        [COORD_BITS:0]   dx_abs;
   logic        [COORD_BITS:0]   dy_abs;
   logic        [ErrBits-1:0]    err_start;
   logic signed [WideBits-1:0]   e2;
   logic signed [WideBits-1:0]   dx_w;
   logic signed [WideBits-1:0]   dy_w;
   logic signed [WideBits-1:0]   err_sum;
   logic                         step_x;
   logic                         step_y;
   logic signed [COORD_BITS-1:0] adv_x;
   logic signed [COORD_BITS-1:0] adv_y;

   assign start = (mode == ModeStart);

   always_comb begin
      dx_full   = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
      dy_full   = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
      dx_abs    = dx_full[COORD_BITS] ? (COORD_BITS+1)'(-dx_full) : dx_full;
      dy_abs    = dy_full[COORD_BITS] ? (COORD_BITS+1)'(-dy_full) : dy_full;
      err_start = ErrBits'({1'b0, dx_abs} - {1'b0, dy_abs});

      e2      = {error_term[ErrBits-1], error_term, 1'b0};
      dx_w    = $signed({4'b0000, delta_x});
      dy_w    = $signed({4'b0000, delta_y});
      step_x  = (e2 > -dy_w);
      step_y  = (e2 < dx_w);
      err_sum = {{2{error_term[ErrBits-1]}}, error_term}
                - (step_x ? dy_w : WideBits'(0))
                + (step_y ? dx_w : WideBits'(0));

      adv_x = cur_x;
      if (step_x) begin
         adv_x = dir.x_neg ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1);
      end
      adv_y = cur_y;
      if (step_y) begin
         adv_y = dir.y_neg ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);
      end

      if (start) begin
         cur_x_in     = x_start;
         cur_y_in     = y_start;
         tgt_x_in     = x_end;
         tgt_y_in     = y_end;
         delta_x_in   = dx_abs[COORD_BITS-1:0];
         delta_y_in   = dy_abs[COORD_BITS-1:0];
         dir_in.x_neg = !(x_start < x_end);
         dir_in.y_neg = !(y_start < y_end);
         error_in     = $signed(err_start);
      end else begin
         cur_x_in   = adv_x;
         cur_y_in   = adv_y;
         tgt_x_in   = tgt_x;
         tgt_y_in   = tgt_y;
         delta_x_in = delta_x;
         delta_y_in = delta_y;
         dir_in     = dir;
         error_in   = err_sum[ErrBits-1:0];
      end

      status.emit = start || busy;
      status.last = (cur_x_in == tgt_x_in) && (cur_y_in == tgt_y_in);
      status.busy = status.emit ? !status.last : busy;
   end

endmodule

[rtl/bresenham_line_rasterizer.sv]
// Bresenham line rasterizer, all octants, one pixel per word.
// A request word with mode 0 loads a line from its two endpoints and gives
// the first pixel. Each request word with mode 1 gives the next pixel of the
// line; the pixel at the end point has last set and the line then ends. An
// advance word while no line is active is consumed and gives no response.
// A start word while a line is active abandons it.
// The csr channel sets the 4-bit color carried by every pixel. It is always
// ready; the user must write it only while the block is idle (not enforced).
// A request word that gives a response has it registered and valid in the
// cycle after. Throughput is one word per cycle while responses are taken:
// each pixel's step and error update are two compares and an add-subtract.
// When the receiver stalls, the response register holds its word and
// req.ready drops until it is taken; a new request is accepted in the same
// cycle that the held response leaves.
// Reset clears the active-line flag and the response valid, and sets the
// color to 15.
module bresenham_line_rasterizer
   import brl_pkg::*;
#(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic  clock,
   input  logic  reset,
   brl_req_if.sink   req,
   brl_rsp_if.source rsp,
   brl_csr_if.sink   csr
);

   localparam int unsigned ErrBits = COORD_BITS + 2;

   logic                         busy_ff;
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_y_ff, tgt_x_ff, tgt_y_ff;
   logic        [COORD_BITS-1:0] delta_x_ff, delta_y_ff;
   brl_dir_type                  dir_ff;
   logic signed [ErrBits-1:0]    error_ff;
   logic [ColorBits-1:0]         color_ff;
   logic                         rsp_valid_ff;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic [ColorBits-1:0]         rsp_color_ff;
   logic                         rsp_last_ff;

   logic signed [COORD_BITS-1:0] cur_x_in, cur_y_in, tgt_x_in, tgt_y_in;
   logic        [COORD_BITS-1:0] delta_x_in, delta_y_in;
   brl_dir_type                  dir_in;
   logic signed [ErrBits-1:0]    error_in;
   brl_status_type               status;
   logic                         req_take;
   logic                         load;

   brl_step #(.COORD_BITS(COORD_BITS)) u_step (
      .mode       (req.mode),
      .x_start    (req.x_start),
      .y_start    (req.y_start),
      .x_end      (req.x_end),
      .y_end      (req.y_end),
      .busy       (busy_ff),
      .cur_x      (cur_x_ff),
      .cur_y      (cur_y_ff),
      .tgt_x      (tgt_x_ff),
      .tgt_y      (tgt_y_ff),
      .delta_x    (delta_x_ff),
      .delta_y    (delta_y_ff),
      .dir        (dir_ff),
      .error_term (error_ff),
      .cur_x_in   (cur_x_in),
      .cur_y_in   (cur_y_in),
      .tgt_x_in   (tgt_x_in),
      .tgt_y_in   (tgt_y_in),
      .delta_x_in (delta_x_in),
      .delta_y_in (delta_y_in),
      .dir_in     (dir_in),
      .error_in   (error_in),
      .status     (status)
   );

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_take  = req.valid && req.ready;
   assign load      = req_take && status.emit;
   assign csr.ready = 1'b1;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pixel_x     = rsp_x_ff;
   assign rsp.pixel_y     = rsp_y_ff;
   assign rsp.pixel_color = rsp_color_ff;
   assign rsp.last        = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         color_ff     <= ColorReset;
      end else begin
         if (csr.valid) begin
            color_ff <= csr.draw_color;
         end
         if (load) begin
            busy_ff      <= status.busy;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         tgt_x_ff     <= tgt_x_in;
         tgt_y_ff     <= tgt_y_in;
         delta_x_ff   <= delta_x_in;
         delta_y_ff   <= delta_y_in;
         dir_ff       <= dir_in;
         error_ff     <= error_in;
         rsp_x_ff     <= cur_x_in;
         rsp_y_ff     <= cur_y_in;
         rsp_color_ff <= color_ff;
         rsp_last_ff  <= status.last;
      end
   end

endmodule

[rtl/brl_checker.sv]
module brl_checker
   import brl_pkg::*;
#(
   parameter int unsigned COORD_BITS = 12
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_mode,
   input logic signed [COORD_BITS-1:0] req_x_start,
   input logic signed [COORD_BITS-1:0] req_y_start,
   input logic signed [COORD_BITS-1:0] req_x_end,
   input logic signed [COORD_BITS-1:0] req_y_end,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [COORD_BITS-1:0] rsp_pixel_x,
   input logic signed [COORD_BITS-1:0] rsp_pixel_y,
   input logic                         rsp_last
);

   // A held response word must not change until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_last))
      else $error("stalled response word changed");

   // With the response register empty the block always takes a request word.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   // A start word yields its first endpoint as the next response.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == ModeStart |=> rsp_valid
         && rsp_pixel_x == $past(req_x_start) && rsp_pixel_y == $past(req_y_start))
      else $error("start word did not give its first pixel");

   // A line whose endpoints coincide is a single pixel marked last.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == ModeStart
         && req_x_start == req_x_end && req_y_start == req_y_end |=> rsp_last)
      else $error("single-pixel line not marked last");

endmodule

bind bresenham_line_rasterizer brl_checker #(.COORD_BITS(COORD_BITS)) u_brl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .req_mode    (req.mode),
   .req_x_start (req.x_start),
   .req_y_start (req.y_start),
   .req_x_end   (req.x_end),
   .req_y_end   (req.y_end),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_pixel_x (rsp.pixel_x),
   .rsp_pixel_y (rsp.pixel_y),
   .rsp_last    (rsp.last)
);
